// ----- hdl/lbr_pkg.sv -----
//------------------------------------------------------------------------------
// lbr_pkg
// Shared types, constants and channel helpers of the letterbox bilinear resizer.
//------------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

   localparam int DIM_BITS  = 8;                 // coordinate bits, 256 pixels per axis
   localparam int FRAC_BITS = 16;                // fractional bits of weights and scale
   localparam int SIZE_BITS = DIM_BITS + 1;      // size registers
   localparam int W_BITS    = FRAC_BITS + 1;     // weight complement range, 0..ONE
   localparam logic [W_BITS-1:0] ONE = W_BITS'(1) << FRAC_BITS;
   localparam int BANK_ABITS = 2 * (DIM_BITS - 1);
   localparam int LERP_BITS  = 8 + FRAC_BITS;
   localparam int ACC_BITS   = 8 + 2 * FRAC_BITS;

   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_PAD_LEVEL  = 3'd4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [7:0]  src_col;
      logic [7:0]  src_row;
      logic [15:0] pixel_565;
      logic [7:0]  dest_col;
      logic [7:0]  dest_row;
   } req_type;

   typedef struct packed {
      logic signed [7:0] blue_q;
      logic signed [7:0] green_q;
      logic signed [7:0] red_q;
      logic [7:0]        pad_left;
      logic [7:0]        pad_top;
      logic [24:0]       scale_q16;
      logic              out_of_range;
   } rsp_type;

   typedef struct packed {
      logic                 busy;
      logic [7:0]           pad_left;
      logic [7:0]           pad_top;
      logic [24:0]          scale;
      logic [SIZE_BITS-1:0] dst_w;
      logic [SIZE_BITS-1:0] dst_h;
      logic [SIZE_BITS-1:0] rsz_w;
      logic [SIZE_BITS-1:0] rsz_h;
      logic [7:0]           pad_q;
   } geom_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  i0;
      logic [DIM_BITS-1:0]  i1;
      logic [FRAC_BITS-1:0] w;
   } tap_type;

   // Channel 0 red, 1 green, 2 blue; each widened to 8 bits by bit replication.
   function automatic logic [7:0] expand_channel(input logic [15:0] px, input int ch);
      logic [7:0] v;
      v = '0;
      case (ch)
         0: v = {px[15:11], px[15:13]};
         1: v = {px[10:5], px[10:9]};
         default: v = {px[4:0], px[4:2]};
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lbr_geom.sv -----
//------------------------------------------------------------------------------
// lbr_geom
// Configuration registers, letterbox geometry and per-axis tap tables, all
// worked out by one shared bit-serial divider after reset and each write.
//------------------------------------------------------------------------------
`default_nettype none

module lbr_geom
   import lbr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [8:0]          csr_wdata,
   input  wire logic                tab_rd_en,
   input  wire logic [DIM_BITS-1:0] tab_x_addr,
   input  wire logic [DIM_BITS-1:0] tab_y_addr,
   output tap_type                  tab_x_q,
   output tap_type                  tab_y_q,
   output geom_type                 geom
);

   localparam int DVD_BITS = 17 + FRAC_BITS;
   localparam int DVS_BITS = SIZE_BITS + 1;
   localparam int CNT_BITS = $clog2(DVD_BITS);
   localparam int PROD_BITS = 2 * SIZE_BITS;

   localparam logic [3:0] ST_DIMS  = 4'd0;
   localparam logic [3:0] ST_CMP   = 4'd1;
   localparam logic [3:0] ST_RLOAD = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_RSAVE = 4'd4;
   localparam logic [3:0] ST_SSAVE = 4'd5;
   localparam logic [3:0] ST_TNUM  = 4'd6;
   localparam logic [3:0] ST_TLOAD = 4'd7;
   localparam logic [3:0] ST_TWR   = 4'd8;
   localparam logic [3:0] ST_IDLE  = 4'd9;

   logic [SIZE_BITS-1:0] cfg_sw_ff, cfg_sh_ff, cfg_dw_ff, cfg_dh_ff;
   logic [7:0]           cfg_pad_ff;
   logic [SIZE_BITS-1:0] sw_ff, sh_ff, dw_ff, dh_ff, rw_ff, rh_ff;
   logic                 horiz_ff;
   logic [24:0]          scale_ff;
   logic [7:0]           padl_ff, padt_ff;
   logic [3:0]           state_ff, ret_ff;
   logic [DVD_BITS-1:0]  quo_ff;
   logic [DVS_BITS-1:0]  rem_ff, dvs_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 axis_ff;
   logic [DIM_BITS-1:0]  d_ff;
   logic [16:0]          num_ff;

   tap_type tab_x [2**DIM_BITS];
   tap_type tab_y [2**DIM_BITS];
   tap_type tap_in;
   logic    tab_we;

   logic [DVS_BITS:0]    trial;
   logic                 fits;
   logic [SIZE_BITS-1:0] s_axis, r_axis;
   logic [16:0]          i0_full;
   logic [SIZE_BITS-1:0] last_idx, i0_clamped, i1_next;
   logic [FRAC_BITS-1:0] w_clamped;

   function automatic logic [SIZE_BITS-1:0] clamp_dim(input logic [SIZE_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      r = v;
      if (v == '0) r = SIZE_BITS'(1);
      else if (v > SIZE_BITS'(2**DIM_BITS)) r = SIZE_BITS'(2**DIM_BITS);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff  <= 9'd224;
         cfg_sh_ff  <= 9'd168;
         cfg_dw_ff  <= 9'd224;
         cfg_dh_ff  <= 9'd224;
         cfg_pad_ff <= 8'd114;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  cfg_sw_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: cfg_sh_ff  <= csr_wdata;
            CSR_DST_WIDTH:  cfg_dw_ff  <= csr_wdata;
            CSR_DST_HEIGHT: cfg_dh_ff  <= csr_wdata;
            CSR_PAD_LEVEL:  cfg_pad_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign trial  = {rem_ff, quo_ff[DVD_BITS-1]};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign s_axis = axis_ff ? sh_ff : sw_ff;
   assign r_axis = axis_ff ? rh_ff : rw_ff;

   // Turn the divider quotient into clamped neighbor indexes and a weight.
   always_comb begin
      i0_full    = quo_ff[FRAC_BITS +: 17];
      last_idx   = s_axis - SIZE_BITS'(1);
      i0_clamped = i0_full[SIZE_BITS-1:0];
      w_clamped  = quo_ff[FRAC_BITS-1:0];
      if (i0_full >= {8'd0, last_idx}) begin
         if (i0_full > {8'd0, last_idx}) w_clamped = '0;
         i0_clamped = last_idx;
      end
      i1_next = (i0_clamped + SIZE_BITS'(1) < s_axis) ? i0_clamped + SIZE_BITS'(1) : last_idx;
      tap_in.i0 = i0_clamped[DIM_BITS-1:0];
      tap_in.i1 = i1_next[DIM_BITS-1:0];
      tap_in.w  = w_clamped;
   end

   assign tab_we = (state_ff == ST_TWR);

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         state_ff <= ST_DIMS;
      end else begin
         unique case (state_ff)
            ST_DIMS: begin
               sw_ff    <= clamp_dim(cfg_sw_ff);
               sh_ff    <= clamp_dim(cfg_sh_ff);
               dw_ff    <= clamp_dim(cfg_dw_ff);
               dh_ff    <= clamp_dim(cfg_dh_ff);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               horiz_ff <= (PROD_BITS'(dw_ff) * PROD_BITS'(sh_ff)) <=
                           (PROD_BITS'(dh_ff) * PROD_BITS'(sw_ff));
               state_ff <= ST_RLOAD;
            end
            ST_RLOAD: begin
               if (horiz_ff) begin
                  quo_ff <= DVD_BITS'(sh_ff * dw_ff);
                  dvs_ff <= DVS_BITS'(sw_ff);
               end else begin
                  quo_ff <= DVD_BITS'(sw_ff * dh_ff);
                  dvs_ff <= DVS_BITS'(sh_ff);
               end
               rem_ff   <= '0;
               cnt_ff   <= '0;
               ret_ff   <= ST_RSAVE;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // One quotient bit per cycle, restoring.
               quo_ff <= {quo_ff[DVD_BITS-2:0], fits};
               rem_ff <= fits ? DVS_BITS'(trial - {1'b0, dvs_ff}) : trial[DVS_BITS-1:0];
               cnt_ff <= cnt_ff + CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(DVD_BITS - 1)) state_ff <= ret_ff;
            end
            ST_RSAVE: begin
               if (horiz_ff) begin
                  rw_ff  <= dw_ff;
                  rh_ff  <= quo_ff[SIZE_BITS-1:0];
                  quo_ff <= DVD_BITS'(dw_ff) << FRAC_BITS;
                  dvs_ff <= DVS_BITS'(sw_ff);
               end else begin
                  rh_ff  <= dh_ff;
                  rw_ff  <= quo_ff[SIZE_BITS-1:0];
                  quo_ff <= DVD_BITS'(dh_ff) << FRAC_BITS;
                  dvs_ff <= DVS_BITS'(sh_ff);
               end
               rem_ff   <= '0;
               cnt_ff   <= '0;
               ret_ff   <= ST_SSAVE;
               state_ff <= ST_DIV;
            end
            ST_SSAVE: begin
               scale_ff <= quo_ff[24:0];
               padl_ff  <= 8'((dw_ff - rw_ff) >> 1);
               padt_ff  <= 8'((dh_ff - rh_ff) >> 1);
               axis_ff  <= 1'b0;
               d_ff     <= '0;
               state_ff <= ST_TNUM;
            end
            ST_TNUM: begin
               num_ff   <= 17'({d_ff, 1'b1} * s_axis);
               state_ff <= ST_TLOAD;
            end
            ST_TLOAD: begin
               rem_ff <= '0;
               cnt_ff <= '0;
               if (num_ff < 17'(r_axis)) begin
                  quo_ff   <= '0;
                  state_ff <= ST_TWR;
               end else begin
                  quo_ff   <= DVD_BITS'(num_ff - 17'(r_axis)) << FRAC_BITS;
                  dvs_ff   <= {r_axis, 1'b0};
                  ret_ff   <= ST_TWR;
                  state_ff <= ST_DIV;
               end
            end
            ST_TWR: begin
               d_ff <= d_ff + DIM_BITS'(1);
               if (d_ff == '1) begin
                  if (axis_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     axis_ff  <= 1'b1;
                     state_ff <= ST_TNUM;
                  end
               end else begin
                  state_ff <= ST_TNUM;
               end
            end
            ST_IDLE: ;
            default: state_ff <= ST_DIMS;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we && !axis_ff) tab_x[d_ff] <= tap_in;
      if (tab_rd_en) tab_x_q <= tab_x[tab_x_addr];
   end

   always_ff @(posedge clock) begin
      if (tab_we && axis_ff) tab_y[d_ff] <= tap_in;
      if (tab_rd_en) tab_y_q <= tab_y[tab_y_addr];
   end

   always_comb begin
      geom.busy     = (state_ff != ST_IDLE);
      geom.pad_left = padl_ff;
      geom.pad_top  = padt_ff;
      geom.scale    = scale_ff;
      geom.dst_w    = dw_ff;
      geom.dst_h    = dh_ff;
      geom.rsz_w    = rw_ff;
      geom.rsz_h    = rh_ff;
      geom.pad_q    = {~cfg_pad_ff[7], cfg_pad_ff[6:0]};
   end

endmodule

`default_nettype wire

// ----- hdl/letterbox_bilinear_resize_rgb565_int8_top.sv -----
//------------------------------------------------------------------------------
// letterbox_bilinear_resize_rgb565_int8_top
// Letterbox bilinear resizer: RGB565 frame store in four banks, int8 output.
//------------------------------------------------------------------------------
// Throughput: one item per cycle while req_stall is low; the frame store is split
// into four banks by row and column parity so the four neighbors are read in parallel.
// Reset and every configuration write start a geometry and tap table pass
// (512 entries on the shared divider) with req_stall held high. The frame
// store itself is not cleared.
`default_nettype none

module letterbox_bilinear_resize_rgb565_int8_top
   import lbr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_data,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [8:0] csr_wdata
);

   geom_type geom;
   tap_type  tab_x_q, tab_y_q;
   logic     adv;

   // Stage 1: classification.
   logic s1_valid_ff, s1_op_ff, s1_oor_ff, s1_pad_ff;
   logic [7:0] s1_col_ff, s1_row_ff, s1_dx_ff, s1_dy_ff;
   logic [15:0] s1_pix_ff;
   logic s1_oor_in, s1_pad_in;
   logic [7:0] dx_in, dy_in;

   // Stage 2: taps.
   logic s2_valid_ff, s2_op_ff, s2_oor_ff, s2_pad_ff;
   logic [7:0] s2_col_ff, s2_row_ff;
   logic [15:0] s2_pix_ff;

   // Stage 3: frame data.
   logic s3_valid_ff, s3_op_ff, s3_oor_ff, s3_pad_ff;
   logic s3_x0_ff, s3_x1_ff, s3_y0_ff, s3_y1_ff;
   logic [FRAC_BITS-1:0] s3_wx_ff, s3_wy_ff;
   logic [15:0] bank_q [4];

   // Stage 4: horizontal blend; stage 5: vertical blend.
   logic s4_valid_ff, s4_op_ff, s4_oor_ff, s4_pad_ff;
   logic [FRAC_BITS-1:0] s4_wy_ff;
   logic [2:0][LERP_BITS-1:0] s4_top_ff, s4_bot_ff, s4_top_in, s4_bot_in;
   logic s5_valid_ff, s5_op_ff, s5_oor_ff, s5_pad_ff;
   logic [2:0][ACC_BITS-1:0] s5_acc_ff, s5_acc_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = geom.busy || !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lbr_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .tab_rd_en  (adv),
      .tab_x_addr (s1_dx_ff),
      .tab_y_addr (s1_dy_ff),
      .tab_x_q    (tab_x_q),
      .tab_y_q    (tab_y_q),
      .geom       (geom)
   );

   always_comb begin
      dx_in     = req_data.dest_col - geom.pad_left;
      dy_in     = req_data.dest_row - geom.pad_top;
      s1_oor_in = ({1'b0, req_data.dest_col} >= geom.dst_w) ||
                  ({1'b0, req_data.dest_row} >= geom.dst_h);
      s1_pad_in = (req_data.dest_col < geom.pad_left) || ({1'b0, dx_in} >= geom.rsz_w) ||
                  (req_data.dest_row < geom.pad_top)  || ({1'b0, dy_in} >= geom.rsz_h);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid && !geom.busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff && (s5_op_ff == OP_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff  <= req_data.op;
         s1_col_ff <= req_data.src_col;
         s1_row_ff <= req_data.src_row;
         s1_pix_ff <= req_data.pixel_565;
         s1_oor_ff <= s1_oor_in;
         s1_pad_ff <= s1_pad_in;
         s1_dx_ff  <= dx_in;
         s1_dy_ff  <= dy_in;

         s2_op_ff  <= s1_op_ff;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
         s2_pix_ff <= s1_pix_ff;
         s2_oor_ff <= s1_oor_ff;
         s2_pad_ff <= s1_pad_ff;

         s3_op_ff  <= s2_op_ff;
         s3_oor_ff <= s2_oor_ff;
         s3_pad_ff <= s2_pad_ff;
         s3_x0_ff  <= tab_x_q.i0[0];
         s3_x1_ff  <= tab_x_q.i1[0];
         s3_y0_ff  <= tab_y_q.i0[0];
         s3_y1_ff  <= tab_y_q.i1[0];
         s3_wx_ff  <= tab_x_q.w;
         s3_wy_ff  <= tab_y_q.w;

         s4_op_ff  <= s3_op_ff;
         s4_oor_ff <= s3_oor_ff;
         s4_pad_ff <= s3_pad_ff;
         s4_wy_ff  <= s3_wy_ff;
         s4_top_ff <= s4_top_in;
         s4_bot_ff <= s4_bot_in;

         s5_op_ff  <= s4_op_ff;
         s5_oor_ff <= s4_oor_ff;
         s5_pad_ff <= s4_pad_ff;
         s5_acc_ff <= s5_acc_in;

         rsp_data_ff <= rsp_data_in;
      end
   end

   // Four frame banks, selected by {row parity, column parity}. A neighbor pair
   // that clamps onto one pixel reads a single bank; the other bank is unused.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [15:0] mem [2**BANK_ABITS];
      logic [6:0]  rd_col, rd_row;
      logic        wr_en;

      assign rd_col = (tab_x_q.i0[0] == b[0]) ? tab_x_q.i0[7:1] : tab_x_q.i1[7:1];
      assign rd_row = (tab_y_q.i0[0] == b[1]) ? tab_y_q.i0[7:1] : tab_y_q.i1[7:1];
      assign wr_en  = adv && s2_valid_ff && (s2_op_ff == OP_WRITE) &&
                      ({s2_row_ff[0], s2_col_ff[0]} == 2'(b));

      always_ff @(posedge clock) begin
         if (wr_en) mem[{s2_row_ff[7:1], s2_col_ff[7:1]}] <= s2_pix_ff;
         if (adv) bank_q[b] <= mem[{rd_row, rd_col}];
      end
   end

   always_comb begin
      logic [15:0] p00, p10, p01, p11;
      logic [W_BITS-1:0] wx_c;
      p00  = bank_q[{s3_y0_ff, s3_x0_ff}];
      p10  = bank_q[{s3_y0_ff, s3_x1_ff}];
      p01  = bank_q[{s3_y1_ff, s3_x0_ff}];
      p11  = bank_q[{s3_y1_ff, s3_x1_ff}];
      wx_c = ONE - W_BITS'(s3_wx_ff);
      for (int ch = 0; ch < 3; ch++) begin
         s4_top_in[ch] = LERP_BITS'(expand_channel(p00, ch) * wx_c +
                                    expand_channel(p10, ch) * W_BITS'(s3_wx_ff));
         s4_bot_in[ch] = LERP_BITS'(expand_channel(p01, ch) * wx_c +
                                    expand_channel(p11, ch) * W_BITS'(s3_wx_ff));
      end
   end

   always_comb begin
      logic [W_BITS-1:0] wy_c;
      wy_c = ONE - W_BITS'(s4_wy_ff);
      for (int ch = 0; ch < 3; ch++) begin
         s5_acc_in[ch] = ACC_BITS'(s4_top_ff[ch] * wy_c + s4_bot_ff[ch] * W_BITS'(s4_wy_ff));
      end
   end

   always_comb begin
      logic [2:0][7:0] q;
      logic [ACC_BITS:0] rnd;
      q = '0;
      for (int ch = 0; ch < 3; ch++) begin
         // Round half up; the blend of 8-bit values never exceeds 255.
         rnd   = {1'b0, s5_acc_ff[ch]} + (ACC_BITS+1)'(1) * (2**(2*FRAC_BITS-1));
         q[ch] = {~rnd[2*FRAC_BITS+7], rnd[2*FRAC_BITS +: 7]};
      end
      rsp_data_in.pad_left     = geom.pad_left;
      rsp_data_in.pad_top      = geom.pad_top;
      rsp_data_in.scale_q16    = geom.scale;
      rsp_data_in.out_of_range = s5_oor_ff;
      if (s5_oor_ff) begin
         rsp_data_in.red_q   = '0;
         rsp_data_in.green_q = '0;
         rsp_data_in.blue_q  = '0;
      end else if (s5_pad_ff) begin
         rsp_data_in.red_q   = geom.pad_q;
         rsp_data_in.green_q = geom.pad_q;
         rsp_data_in.blue_q  = geom.pad_q;
      end else begin
         rsp_data_in.red_q   = q[0];
         rsp_data_in.green_q = q[1];
         rsp_data_in.blue_q  = q[2];
      end
   end

endmodule

`default_nettype wire
